>>> hdl/dts_pkg.sv
// Package for the depth-first topological sort block.
// Types, sizes and codes shared by the memory, search engine and top level.
package dts_pkg;
   localparam int NUM_VERTICES = 16;
   localparam int VW = $clog2(NUM_VERTICES);
   localparam int CW = $clog2(NUM_VERTICES + 1);

   typedef logic [1:0] op_type;
   localparam op_type OP_ADD   = 2'd0;
   localparam op_type OP_CLEAR = 2'd1;
   localparam op_type OP_SORT  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLEAR, ST_ROOT, ST_READ, ST_STEP, ST_EMIT
   } state_type;

   typedef struct packed {
      logic                    we;
      logic [VW-1:0]           waddr;
      logic [NUM_VERTICES-1:0] wdata;
      logic [VW-1:0]           raddr;
   } adj_cmd_type;
endpackage

>>> hdl/dts_adj_mem.sv
// Adjacency matrix memory: one row per source vertex, registered read.
// Depends on dts_pkg.
module dts_adj_mem import dts_pkg::*; (
   input  logic                    clock,
   input  adj_cmd_type             cmd,
   output logic [NUM_VERTICES-1:0] rdata
);
   logic [NUM_VERTICES-1:0] mem [NUM_VERTICES];
   always_ff @(posedge clock) begin
      if (cmd.we) mem[cmd.waddr] <= cmd.wdata;
      rdata <= mem[cmd.raddr];
   end
endmodule

>>> hdl/dfs_topological_sort.sv
// Depth-first topological sort over an adjacency memory.
// Add arc: read row then write back. Clear: one row per cycle over all NUM_VERTICES rows.
// Sort: one memory read per stack step, each examined neighbor is read then stepped (ST_READ,
// ST_STEP), then one transaction out per cycle while rsp_stall is low. Input stalls meanwhile.
// Synchronous active-high reset sweeps the adjacency memory to zero, all NUM_VERTICES rows.
module dfs_topological_sort import dts_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic [4:0]    csr_write_data,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_operation,
   input  logic [3:0]    req_from_vertex,
   input  logic [3:0]    req_to_vertex,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [3:0]    rsp_vertex,
   output logic          rsp_has_cycle,
   output logic          rsp_last
);
   logic [4:0] vcount_ff;
   state_type state_ff, state_in;
   logic [VW-1:0] cnt_ff, cnt_in;           // clear sweep row / root / emit index
   logic [CW-1:0] sp_ff, sp_in;             // stack depth
   logic [CW-1:0] fin_ff, fin_in;           // finish count
   logic [NUM_VERTICES-1:0] vis_ff, vis_in, done_ff, done_in;
   logic cyc_ff, cyc_in;
   logic add_ff, add_in;                    // pending arc write-back
   logic [VW-1:0] afrom_ff, afrom_in, ato_ff, ato_in;
   // search stack: vertex and next neighbor per frame (register file, top read only)
   logic [VW-1:0] stv_ff [NUM_VERTICES];
   logic [CW-1:0] stn_ff [NUM_VERTICES];
   logic [VW-1:0] ord_ff [NUM_VERTICES];
   logic st_we, ord_we;
   logic [VW-1:0] st_wa, st_wv;
   logic [CW-1:0] st_wn;
   adj_cmd_type cmd;
   logic [NUM_VERTICES-1:0] row, inuse, cand;
   logic [CW-1:0] vc;
   logic [VW-1:0] topv, nsel, eidx;
   logic [CW-1:0] topn;
   logic found;

   dts_adj_mem u_mem (.clock(clock), .cmd(cmd), .rdata(row));

   always_comb begin
      vc = (vcount_ff == 5'd0) ? CW'(1) :
           (32'(vcount_ff) > NUM_VERTICES) ? CW'(NUM_VERTICES) : CW'(vcount_ff);
      for (int i = 0; i < NUM_VERTICES; i++) inuse[i] = (i < vc);
   end

   assign topv = stv_ff[VW'(sp_ff - CW'(1))];
   assign topn = stn_ff[VW'(sp_ff - CW'(1))];

   // lowest set neighbor at or above topn: priority encoder over one row
   always_comb begin
      found = 1'b0;
      nsel = '0;
      for (int i = 0; i < NUM_VERTICES; i++) cand[i] = row[i] & inuse[i] & (i >= topn);
      for (int i = NUM_VERTICES - 1; i >= 0; i--)
         if (cand[i]) begin found = 1'b1; nsel = VW'(i); end
   end

   assign eidx = VW'(fin_ff - CW'(1) - CW'(cnt_ff));
   assign req_stall = (state_ff != ST_IDLE) || add_ff;
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_has_cycle = cyc_ff || (fin_ff == '0);
   assign rsp_vertex = rsp_has_cycle ? 4'd0 : 4'(ord_ff[eidx]);
   assign rsp_last = rsp_has_cycle || (CW'(cnt_ff) + CW'(1) == fin_ff);

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; sp_in = sp_ff; fin_in = fin_ff;
      vis_in = vis_ff; done_in = done_ff; cyc_in = cyc_ff;
      add_in = 1'b0; afrom_in = afrom_ff; ato_in = ato_ff;
      cmd = '{we: 1'b0, waddr: '0, wdata: '0, raddr: '0};
      st_we = 1'b0; st_wa = '0; st_wv = '0; st_wn = '0; ord_we = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (add_ff) begin
               cmd.we = 1'b1; cmd.waddr = afrom_ff;
               cmd.wdata = row | (NUM_VERTICES'(1) << ato_ff);
            end else if (req_valid) begin
               case (req_operation)
                  OP_ADD: begin
                     if (CW'(req_from_vertex) < vc && CW'(req_to_vertex) < vc) begin
                        add_in = 1'b1;
                        afrom_in = VW'(req_from_vertex); ato_in = VW'(req_to_vertex);
                        cmd.raddr = VW'(req_from_vertex);
                     end
                  end
                  OP_CLEAR: begin state_in = ST_CLEAR; cnt_in = '0; end
                  OP_SORT: begin
                     state_in = ST_ROOT; cnt_in = '0; sp_in = '0; fin_in = '0;
                     vis_in = '0; done_in = '0; cyc_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.we = 1'b1; cmd.waddr = cnt_ff;
            cnt_in = cnt_ff + VW'(1);
            if (cnt_ff == VW'(NUM_VERTICES - 1)) state_in = ST_IDLE;
         end
         ST_ROOT: begin
            if (CW'(cnt_ff) >= vc) begin
               state_in = ST_EMIT; cnt_in = '0;
            end else if (vis_ff[cnt_ff]) begin
               if (cnt_ff == VW'(NUM_VERTICES - 1)) begin state_in = ST_EMIT; cnt_in = '0; end
               else cnt_in = cnt_ff + VW'(1);
            end else begin
               st_we = 1'b1; st_wa = VW'(sp_ff); st_wv = cnt_ff; st_wn = '0;
               sp_in = sp_ff + CW'(1); vis_in[cnt_ff] = 1'b1;
               cmd.raddr = cnt_ff; state_in = ST_STEP;
            end
         end
         ST_READ: begin
            cmd.raddr = topv; state_in = ST_STEP;
         end
         ST_STEP: begin
            if (found) begin
               st_we = 1'b1; st_wa = VW'(sp_ff - CW'(1)); st_wv = topv;
               st_wn = CW'(nsel) + CW'(1);
               if (!vis_ff[nsel]) begin
                  st_wa = VW'(sp_ff - CW'(1));
                  vis_in[nsel] = 1'b1;
                  sp_in = sp_ff + CW'(1);
               end else if (!done_ff[nsel]) cyc_in = 1'b1;
               state_in = ST_READ;
            end else begin
               done_in[topv] = 1'b1; ord_we = 1'b1;
               fin_in = fin_ff + CW'(1); sp_in = sp_ff - CW'(1);
               state_in = (sp_ff == CW'(1)) ? ST_ROOT : ST_READ;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               cnt_in = cnt_ff + VW'(1);
               if (rsp_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (reset) cmd.we = 1'b1;
   end

   // push writes the child frame above the updated parent
   always_ff @(posedge clock) begin
      if (st_we) begin
         stv_ff[st_wa] <= st_wv; stn_ff[st_wa] <= st_wn;
      end
      if (state_ff == ST_STEP && found && !vis_ff[nsel]) begin
         stv_ff[VW'(sp_ff)] <= nsel; stn_ff[VW'(sp_ff)] <= '0;
      end
      if (ord_we) ord_ff[VW'(fin_ff)] <= topv;
      afrom_ff <= afrom_in; ato_ff <= ato_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; cnt_ff <= '0; sp_ff <= '0; fin_ff <= '0;
         vis_ff <= '0; done_ff <= '0; cyc_ff <= 1'b0; add_ff <= 1'b0;
         vcount_ff <= 5'd16;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; sp_ff <= sp_in; fin_ff <= fin_in;
         vis_ff <= vis_in; done_ff <= done_in; cyc_ff <= cyc_in; add_ff <= add_in;
         if (csr_write_enable) vcount_ff <= csr_write_data;
      end
   end

`ifndef SYNTHESIS
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall) else $error("input accepted while busy");
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= CW'(NUM_VERTICES)) else $error("stack overflow");
   a_emit_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> (state_ff == ST_IDLE))
      else $error("emit did not end");
`endif
endmodule
